### hdl/kcdv_pkg.sv
// Shared types, constants and the check digit alphabet for the key check digit verifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package kcdv_pkg;

    localparam int CHAR_W           = 8;
    localparam int HASH_W           = 28;
    localparam int DIGIT_W          = 6;
    localparam int HASHED_CHARS_DEF = 9;
    localparam int CHECK_DIGITS_DEF = 4;

    // x / 9 for x below 2**26: (x * DIV9_MULT) >> DIV9_SHIFT
    localparam int              DIV9_SHIFT = 30;
    localparam logic [26:0]     DIV9_MULT  = 27'd119304648;

    localparam logic [1:0] VERDICT_MATCH      = 2'd0;
    localparam logic [1:0] VERDICT_MISMATCH   = 2'd1;
    localparam logic [1:0] VERDICT_SHORT_KEY  = 2'd2;
    localparam logic [1:0] VERDICT_SHORT_HASH = 2'd3;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] quo;
        logic              short_key;
        logic              zero_seen;
        logic              mismatch;
    } kcdv_pkt_t;

    // scrambled base-36 symbol set
    function automatic logic [CHAR_W-1:0] kcdv_symbol(input logic [DIGIT_W-1:0] idx);
        logic [CHAR_W-1:0] sym;
        case (idx)
            6'd0:    sym = 8'h30;
            6'd1:    sym = 8'h50;
            6'd2:    sym = 8'h39;
            6'd3:    sym = 8'h4F;
            6'd4:    sym = 8'h38;
            6'd5:    sym = 8'h49;
            6'd6:    sym = 8'h37;
            6'd7:    sym = 8'h55;
            6'd8:    sym = 8'h36;
            6'd9:    sym = 8'h59;
            6'd10:   sym = 8'h35;
            6'd11:   sym = 8'h54;
            6'd12:   sym = 8'h34;
            6'd13:   sym = 8'h52;
            6'd14:   sym = 8'h33;
            6'd15:   sym = 8'h45;
            6'd16:   sym = 8'h32;
            6'd17:   sym = 8'h57;
            6'd18:   sym = 8'h31;
            6'd19:   sym = 8'h51;
            6'd20:   sym = 8'h4C;
            6'd21:   sym = 8'h4B;
            6'd22:   sym = 8'h4A;
            6'd23:   sym = 8'h48;
            6'd24:   sym = 8'h47;
            6'd25:   sym = 8'h46;
            6'd26:   sym = 8'h44;
            6'd27:   sym = 8'h53;
            6'd28:   sym = 8'h4D;
            6'd29:   sym = 8'h4E;
            6'd30:   sym = 8'h42;
            6'd31:   sym = 8'h56;
            6'd32:   sym = 8'h43;
            6'd33:   sym = 8'h58;
            6'd34:   sym = 8'h41;
            6'd35:   sym = 8'h5A;
            default: sym = 8'h00;
        endcase
        return sym;
    endfunction

endpackage

### hdl/kcdv_accum.sv
// Input register, running ELF hash, tail shift register and end-of-key snapshot register.
// Depends on kcdv_pkg.
`timescale 1ns / 1ps

module kcdv_accum
    import kcdv_pkg::*;
#(
    parameter int HASHED_CHARS = HASHED_CHARS_DEF,
    parameter int CHECK_DIGITS = CHECK_DIGITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [CHAR_W-1:0]                in_char,
    input  logic                             in_last,
    output logic                             snap_valid,
    input  logic                             snap_ready,
    output kcdv_pkt_t                        snap_pkt,
    output logic [CHECK_DIGITS*CHAR_W-1:0]   snap_tail
);

    localparam int HC_W = $clog2(HASHED_CHARS + 1);
    localparam int CC_W = $clog2(CHECK_DIGITS + 1);

    logic                                   in_valid_reg;
    logic [CHAR_W-1:0]                      char_reg;
    logic                                   last_reg;

    logic [HASH_W-1:0]                      hash_reg;
    logic [HASH_W-1:0]                      hash_next;
    logic [HC_W-1:0]                        hcnt_reg;
    logic [HC_W-1:0]                        hcnt_next;
    logic [CC_W-1:0]                        ccnt_reg;
    logic [CC_W-1:0]                        ccnt_next;
    logic [CHECK_DIGITS-1:0][CHAR_W-1:0]    tail_reg;
    logic [CHECK_DIGITS-1:0][CHAR_W-1:0]    tail_next;

    logic                                   snap_valid_reg;
    kcdv_pkt_t                              snap_pkt_reg;
    logic [CHECK_DIGITS*CHAR_W-1:0]         snap_tail_reg;

    logic [31:0]                            h_sum;
    logic [HASH_W-1:0]                      h_elf;
    logic                                   snap_free;
    logic                                   in_take;
    logic                                   snap_load;

    always_comb
    begin
        h_sum = {hash_reg, 4'b0000} + 32'(char_reg);
        h_elf = {h_sum[27:8], h_sum[7:4] ^ h_sum[31:28], h_sum[3:0]};

        if (hcnt_reg < HC_W'(HASHED_CHARS))
        begin
            hash_next = h_elf;
            hcnt_next = hcnt_reg + HC_W'(1);
        end
        else
        begin
            hash_next = hash_reg;
            hcnt_next = hcnt_reg;
        end

        tail_next[0] = char_reg;
        for (int i = 1; i < CHECK_DIGITS; i++)
        begin
            tail_next[i] = tail_reg[i-1];
        end

        if (ccnt_reg < CC_W'(CHECK_DIGITS))
        begin
            ccnt_next = ccnt_reg + CC_W'(1);
        end
        else
        begin
            ccnt_next = ccnt_reg;
        end
    end

    // non-final chars never wait on the result side
    assign snap_free = !snap_valid_reg || snap_ready;
    assign in_take   = in_valid_reg && (!last_reg || snap_free);
    assign snap_load = in_take && last_reg;
    assign in_ready  = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            hcnt_reg <= '0;
            ccnt_reg <= '0;
            tail_reg <= '0;
        end
        else if (in_take)
        begin
            if (last_reg)
            begin
                hash_reg <= '0;
                hcnt_reg <= '0;
                ccnt_reg <= '0;
                tail_reg <= '0;
            end
            else
            begin
                hash_reg <= hash_next;
                hcnt_reg <= hcnt_next;
                ccnt_reg <= ccnt_next;
                tail_reg <= tail_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (snap_load)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_pkt_reg.hash      <= hash_next;
            snap_pkt_reg.quo       <= hash_next;
            snap_pkt_reg.short_key <= (ccnt_next < CC_W'(CHECK_DIGITS));
            snap_pkt_reg.zero_seen <= 1'b0;
            snap_pkt_reg.mismatch  <= 1'b0;
            snap_tail_reg          <= tail_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_pkt   = snap_pkt_reg;
    assign snap_tail  = snap_tail_reg;

    a_ccnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ccnt_reg <= CC_W'(CHECK_DIGITS))
        else $error("char count beyond check digit count");

    a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hcnt_reg <= HC_W'(HASHED_CHARS))
        else $error("hashed count beyond limit");

    a_clear_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> (ccnt_reg == '0) && (hcnt_reg == '0) && (hash_reg == '0) && snap_valid_reg)
        else $error("key state not cleared after final char");

endmodule

### hdl/kcdv_digit.sv
// One base-36 digit stage: divides the running quotient by 36 and checks one tail char.
// Depends on kcdv_pkg.
`timescale 1ns / 1ps

module kcdv_digit
    import kcdv_pkg::*;
#(
    parameter int CHECK_DIGITS = CHECK_DIGITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  kcdv_pkt_t                        up_pkt,
    input  logic [CHECK_DIGITS*CHAR_W-1:0]   up_tail,
    output logic                             dn_valid,
    input  logic                             dn_ready,
    output kcdv_pkt_t                        dn_pkt,
    output logic [CHECK_DIGITS*CHAR_W-1:0]   dn_tail
);

    logic                             valid_reg;
    kcdv_pkt_t                        pkt_reg;
    kcdv_pkt_t                        pkt_next;
    logic [CHECK_DIGITS*CHAR_W-1:0]   tail_reg;
    logic [CHECK_DIGITS*CHAR_W-1:0]   tail_next;

    logic [52:0]                      prod;
    logic [22:0]                      quot;
    logic [HASH_W-1:0]                rem_full;
    logic [DIGIT_W-1:0]               rem;
    logic                             load;

    always_comb
    begin
        // q / 36 = (q >> 2) / 9
        prod     = 53'(up_pkt.quo[HASH_W-1:2]) * 53'(DIV9_MULT);
        quot     = prod[52:DIV9_SHIFT];
        rem_full = up_pkt.quo - (28'({quot, 5'b00000}) + 28'({quot, 2'b00}));
        rem      = rem_full[DIGIT_W-1:0];

        pkt_next           = up_pkt;
        pkt_next.quo       = 28'(quot);
        pkt_next.zero_seen = up_pkt.zero_seen || (up_pkt.quo == '0);
        pkt_next.mismatch  = up_pkt.mismatch || (kcdv_symbol(rem) != up_tail[CHAR_W-1:0]);
        tail_next          = up_tail >> CHAR_W;
    end

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg  <= pkt_next;
            tail_reg <= tail_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_pkt   = pkt_reg;
    assign dn_tail  = tail_reg;

    a_zero_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && pkt_reg.zero_seen |-> (pkt_reg.quo == '0))
        else $error("zero flag set with nonzero quotient");

    a_quo_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (pkt_reg.quo <= $past(up_pkt.quo)))
        else $error("quotient grew across digit stage");

endmodule

### hdl/key_check_digit_verifier.sv
// Key check digit verifier: hashes the leading key chars, checks the trailing chars
// against base-36 digits of the hash. Depends on kcdv_pkg, kcdv_accum, kcdv_digit.
// After the final char is accepted, its key passes the input register, the snapshot register and the kcdv_digit stages.
// Throughput: one char per cycle; the hash and tail update once per char in kcdv_accum.
// Only a final char waits on a full result side, and the input stalls behind it.
// Reset clears hash, counts, tail and all pipeline valids; the block is ready right after.
`timescale 1ns / 1ps

module key_check_digit_verifier
    import kcdv_pkg::*;
#(
    parameter int HASHED_CHARS = HASHED_CHARS_DEF,
    parameter int CHECK_DIGITS = CHECK_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_char
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] verdict, [29:2] hash_value, [31:30] zero
);

    logic                             stg_valid [CHECK_DIGITS+1];
    logic                             stg_ready [CHECK_DIGITS+1];
    kcdv_pkt_t                        stg_pkt   [CHECK_DIGITS+1];
    logic [CHECK_DIGITS*CHAR_W-1:0]   stg_tail  [CHECK_DIGITS+1];

    kcdv_pkt_t                        res;
    logic [1:0]                       verdict;

    kcdv_accum #(
        .HASHED_CHARS (HASHED_CHARS),
        .CHECK_DIGITS (CHECK_DIGITS)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .snap_valid (stg_valid[0]),
        .snap_ready (stg_ready[0]),
        .snap_pkt   (stg_pkt[0]),
        .snap_tail  (stg_tail[0])
    );

    for (genvar k = 0; k < CHECK_DIGITS; k++)
    begin : g_digit
        kcdv_digit #(
            .CHECK_DIGITS (CHECK_DIGITS)
        ) u_digit (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[k]),
            .up_ready (stg_ready[k]),
            .up_pkt   (stg_pkt[k]),
            .up_tail  (stg_tail[k]),
            .dn_valid (stg_valid[k+1]),
            .dn_ready (stg_ready[k+1]),
            .dn_pkt   (stg_pkt[k+1]),
            .dn_tail  (stg_tail[k+1])
        );
    end

    assign res                       = stg_pkt[CHECK_DIGITS];
    assign stg_ready[CHECK_DIGITS]   = m_axis_tready;

    always_comb
    begin
        if (res.short_key)
        begin
            verdict = VERDICT_SHORT_KEY;
        end
        else if (res.zero_seen)
        begin
            verdict = VERDICT_SHORT_HASH;
        end
        else if (res.mismatch)
        begin
            verdict = VERDICT_MISMATCH;
        end
        else
        begin
            verdict = VERDICT_MATCH;
        end
    end

    assign m_axis_tvalid = stg_valid[CHECK_DIGITS];
    assign m_axis_tdata  = {2'b00, res.hash, verdict};

    a_tail_drained: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (stg_tail[CHECK_DIGITS] == '0))
        else $error("tail chars left unchecked at result");

endmodule

### tb/sv/key_check_digit_verifier_test.sv
// Self-checking testbench for key_check_digit_verifier: streams keys one char per item,
// predicts the ELF hash and base-36 check digit verdict, and compares every result.
// Depends on kcdv_pkg and the key_check_digit_verifier RTL.
`timescale 1ns / 1ps

module key_check_digit_verifier_test;
    import kcdv_pkg::*;

    localparam int HASH_CHARS  = HASHED_CHARS_DEF;
    localparam int CHECK_CHARS = CHECK_DIGITS_DEF;
    localparam logic [8*36-1:0] SYMBOLS = "0P9O8I7U6Y5T4R3E2W1QLKJHGFDSMNBVCXAZ";

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } key_item_t;

    typedef struct packed {
        logic [1:0]        verdict;
        logic [HASH_W-1:0] hash;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] key_char
    logic        s_axis_tlast = 1'b0;    // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [1:0] verdict, [29:2] hash_value

    key_item_t key_stream[$];
    verdict_t  verdicts_due[$];

    // predictor state
    logic [HASH_W-1:0] key_hash;
    int                hashed_n;
    logic [7:0]        tail_chars[CHECK_CHARS];
    int                seen_n;

    logic char_taken = 1'b0;
    logic hold_off = 1'b0;
    int   verdicts_seen = 0;
    int   mismatches = 0;

    key_check_digit_verifier DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] check_symbol(input int idx);
        return SYMBOLS[8*(35-idx) +: 8];
    endfunction

    function automatic logic [HASH_W-1:0] elf_mix(input logic [HASH_W-1:0] acc,
                                                  input logic [7:0] ch);
        logic [31:0] h;
        logic [31:0] g;
        h = {acc, 4'h0} + {24'h0, ch};
        g = h & 32'hF000_0000;
        if (g != 32'h0)
            h = h ^ (g >> 24);
        h = h & ~g;
        return h[HASH_W-1:0];
    endfunction

    task automatic clear_key_state();
        key_hash = '0;
        hashed_n = 0;
        seen_n   = 0;
        for (int a = 0; a < CHECK_CHARS; a++)
            tail_chars[a] = 8'h00;
    endtask

    task automatic absorb_char(input logic [7:0] ch, input logic last);
        verdict_t          want;
        logic [HASH_W-1:0] q;
        logic              done;
        if (hashed_n < HASH_CHARS)
        begin
            key_hash = elf_mix(key_hash, ch);
            hashed_n++;
        end
        for (int a = CHECK_CHARS - 1; a > 0; a--)
            tail_chars[a] = tail_chars[a-1];
        tail_chars[0] = ch;
        if (seen_n < CHECK_CHARS)
            seen_n++;
        if (last)
        begin
            want.hash = key_hash;
            if (seen_n < CHECK_CHARS)
                want.verdict = VERDICT_SHORT_KEY;
            else
            begin
                want.verdict = VERDICT_MATCH;
                q = key_hash;
                done = 1'b0;
                for (int a = 0; a < CHECK_CHARS; a++)
                begin
                    if (!done)
                    begin
                        if (q == '0)
                        begin
                            want.verdict = VERDICT_SHORT_HASH;
                            done = 1'b1;
                        end
                        else
                        begin
                            if (check_symbol(q % 36) != tail_chars[a])
                                want.verdict = VERDICT_MISMATCH;
                            q = q / 36;
                        end
                    end
                end
            end
            verdicts_due.push_back(want);
            clear_key_state();
        end
    endtask

    // appends the check digits that make the key pass, most significant first
    task automatic add_check_digits(ref logic [7:0] k[$]);
        logic [HASH_W-1:0] h;
        logic [7:0]        dig[CHECK_CHARS];
        h = '0;
        for (int i = 0; i < HASH_CHARS && i < k.size(); i++)
            h = elf_mix(h, k[i]);
        for (int a = 0; a < CHECK_CHARS; a++)
        begin
            dig[a] = check_symbol(h % 36);
            h = h / 36;
        end
        for (int a = CHECK_CHARS - 1; a >= 0; a--)
            k.push_back(dig[a]);
    endtask

    task automatic queue_key(input logic [7:0] k[$]);
        key_item_t it;
        for (int i = 0; i < k.size(); i++)
        begin
            it.ch   = k[i];
            it.last = (i == k.size() - 1);
            key_stream.push_back(it);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        key_item_t nxt;
        logic      steady;
        steady = key_stream.size() >= 200 && key_stream.size() < 350;
        if (rst_n && (!s_axis_tvalid || char_taken))
        begin
            if (key_stream.size() != 0 && (steady || $urandom_range(0, 99) >= 18))
            begin
                nxt = key_stream.pop_front();
                s_axis_tdata  <= nxt.ch;
                s_axis_tlast  <= nxt.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result side ready
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else if (verdicts_seen >= 20 && verdicts_seen < 40)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 18);
    end

    // monitor: predict on accepted chars, then check accepted results
    always @(posedge clk)
    begin
        verdict_t want;
        char_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (char_taken)
            absorb_char(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: verdict %0d hash %07h",
                             m_axis_tdata[1:0], m_axis_tdata[29:2]);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (m_axis_tdata[1:0] !== want.verdict || m_axis_tdata[29:2] !== want.hash)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected verdict %0d hash %07h, got verdict %0d hash %07h",
                                 want.verdict, want.hash,
                                 m_axis_tdata[1:0], m_axis_tdata[29:2]);
                end
            end
        end
    end

    // long result stall so the block backs up into its input
    initial
    begin
        wait (verdicts_seen >= 8);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2400000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [7:0] k[$];
        int         queued;
        int         pick;
        int         n;
        clear_key_state();

        // directed keys
        queue_key('{8'hFF});
        queue_key('{8'h01, 8'h80, 8'hFF});
        queue_key('{8'h01, 8'h01, 8'h01, 8'h01});
        queue_key('{8'h00, 8'h00, 8'h00, 8'h00});
        k = '{8'hFF, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'h55, 8'hAA, 8'h02, 8'hFF};
        add_check_digits(k);
        queue_key(k);

        queued = 0;
        while (queued < 800)
        begin
            k.delete();
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                for (int i = 0; i < HASH_CHARS; i++)
                    k.push_back(8'($urandom_range(1, 255)));
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    k.push_back(8'($urandom_range(1, 255)));
                add_check_digits(k);
                if (pick >= 60)
                begin
                    n = k.size() - 1 - $urandom_range(0, CHECK_CHARS - 1);
                    k[n] = k[n] ^ (8'h01 << $urandom_range(0, 6));
                end
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 30);
                for (int i = 0; i < n; i++)
                    k.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    k.push_back(8'($urandom_range(1, 15)));
            end
            queue_key(k);
            queued += k.size();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (key_stream.size() == 0);
        @(posedge clk);
        wait (!s_axis_tvalid);
        wait (verdicts_due.size() == 0);
        repeat (12) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
